FILE: sv/sxe_pkg.sv
// shared types, constants and register codes for the sobel x edge threshold block
package sxe_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT  = 4096;

    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 13;
    localparam int THR_W        = 11;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int ROW_W        = 12;
    localparam int CHAN_W       = 8;
    localparam int SUM_W        = 11;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RST  = 11'd640;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [THR_W-1:0]        THR_RST    = 11'd150;

    localparam logic [CHAN_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [CHAN_W-1:0] EDGE_OFF = 8'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_EDGE_THRESHOLD = 2'd2
    } cfg_reg_e;

    // channel 0 red, 1 green, 2 blue
    typedef logic [2:0][CHAN_W-1:0] pixel_t;
    typedef logic [2:0][CHAN_W-1:0] result_t;

    // tap index 0 is column c-1, 2 is column c-3
    typedef struct packed {
        logic            col_zero;
        logic [1:0]      c3_tap;
        logic            use_cur;
        logic [2:0][1:0] line_sel;
    } win_ctl_t;

endpackage

FILE: sv/sxe_line_store.sv
// three line memories with column tap registers and current row taps
module sxe_line_store #(
    parameter int MAX_WIDTH = sxe_pkg::MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(MAX_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          push,
    input  logic [1:0]                    wr_line,
    input  logic [ADDR_W-1:0]             addr,
    input  sxe_pkg::pixel_t               wr_pixel,
    output sxe_pkg::pixel_t [2:0][2:0]    line_tap,
    output sxe_pkg::pixel_t [2:0]         cur_tap
);
    import sxe_pkg::*;

    pixel_t cur0_reg, cur1_reg, cur2_reg;

    for (genvar l = 0; l < 3; l++) begin : g_line
        pixel_t mem [MAX_WIDTH];
        pixel_t rd_reg, d1_reg, d2_reg;

        always_ff @(posedge aclk) begin
            if (push) begin
                rd_reg <= mem[addr];
                d1_reg <= rd_reg;
                d2_reg <= d1_reg;
                if (wr_line == 2'(l)) begin
                    mem[addr] <= wr_pixel;
                end
            end
        end

        assign line_tap[l] = {d2_reg, d1_reg, rd_reg};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            cur0_reg <= wr_pixel;
            cur1_reg <= cur0_reg;
            cur2_reg <= cur1_reg;
        end
    end

    assign cur_tap = {cur2_reg, cur1_reg, cur0_reg};

endmodule

FILE: sv/sxe_gradient.sv
// weighted column difference per channel and threshold compare
module sxe_gradient (
    input  sxe_pkg::pixel_t [2:0][2:0]        line_tap,
    input  sxe_pkg::pixel_t [2:0]             cur_tap,
    input  sxe_pkg::win_ctl_t                 ctl,
    input  logic signed [sxe_pkg::THR_W-1:0]  threshold,
    output sxe_pkg::result_t                  result
);
    import sxe_pkg::*;

    always_comb begin
        logic [CHAN_W-1:0]      pa;
        logic [CHAN_W-1:0]      pb;
        logic signed [9:0]      diff;
        logic signed [SUM_W-1:0] sum;
        for (int ch = 0; ch < 3; ch++) begin
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                if (ctl.use_cur) begin
                    pa = cur_tap[ctl.c3_tap][ch];
                    pb = cur_tap[0][ch];
                end else begin
                    pa = line_tap[ctl.line_sel[i]][ctl.c3_tap][ch];
                    pb = line_tap[ctl.line_sel[i]][0][ch];
                end
                diff = $signed({2'b00, pa}) - $signed({2'b00, pb});
                if (i == 1) begin
                    diff = diff <<< 1;
                end
                sum = sum + SUM_W'(diff);
            end
            if (ctl.col_zero) begin
                sum = '0;
            end
            result[ch] = (sum >= threshold) ? EDGE_ON : EDGE_OFF;
        end
    end

endmodule

FILE: sv/sxe_out_skid.sv
// result register with one skid entry
module sxe_out_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  sxe_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output sxe_pkg::result_t out_data
);
    import sxe_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg   <= skid_data_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_data_reg  <= in_data;
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_data_reg  <= in_data;
            skid_valid_reg <= 1'b1;
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid entry filled without an output stall");

endmodule

FILE: sv/sobel_x_rgb_edge_threshold.sv
// top level: position counters, configuration registers, line store, gradient and output
//
//  channel  | direction | tdata / data (lowest bit up)            | handshake
//  s_       | in        | red, green, blue (8 bits each)          | s_tvalid / s_tready
//  m_       | out       | edge_red, edge_green, edge_blue         | m_tvalid / m_tready
//  cfg_     | in        | 0 image_width, 1 image_height, 2 thr    | cfg_we, no wait
//
// one pixel per cycle while s_tready is high; a result is registered at its transaction
// each line memory is read once per transaction and one is written, which sets the rate
// aresetn clears counters and valid flags and resets configuration; memories are not cleared
// a stalled output holds one result and one in the skid entry before s_tready drops
module sobel_x_rgb_edge_threshold #(
    parameter int MAX_WIDTH = sxe_pkg::MAX_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sxe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sxe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red, green, blue
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata    // edge_red, edge_green, edge_blue
);
    import sxe_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int WW     = (COL_W > WIDTH_CFG_W) ? COL_W : WIDTH_CFG_W;

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic signed [THR_W-1:0] thr_reg;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [1:0]              mod_reg, mod_next;

    logic                    push;
    logic [WW-1:0]           eff_w, width_ext;
    logic [HEIGHT_CFG_W-1:0] eff_h, r_pre;
    logic                    wrap_col;
    logic [1:0]              m_pre, m_inc, m_dec;
    logic [COL_W-1:0]        cur_c;
    win_ctl_t                ctl;
    pixel_t [2:0][2:0]       line_tap;
    pixel_t [2:0]            cur_tap;
    result_t                 grad_result, out_result;

    assign push = s_tvalid && s_tready;

    always_comb begin
        width_ext = WW'(width_reg);
        if (width_reg == '0) begin
            eff_w = WW'(1);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = width_ext;
        end

        if (height_reg == '0) begin
            eff_h = HEIGHT_CFG_W'(1);
        end else if (height_reg > HEIGHT_CFG_W'(HEIGHT_LIMIT)) begin
            eff_h = HEIGHT_CFG_W'(HEIGHT_LIMIT);
        end else begin
            eff_h = height_reg;
        end

        wrap_col = WW'(col_reg) >= eff_w;
        cur_c    = wrap_col ? '0 : col_reg;
        m_inc    = (mod_reg == 2'd2) ? 2'd0 : mod_reg + 2'd1;
        r_pre    = wrap_col ? HEIGHT_CFG_W'(row_reg) + HEIGHT_CFG_W'(1)
                            : HEIGHT_CFG_W'(row_reg);
        m_pre    = wrap_col ? m_inc : mod_reg;

        if (r_pre >= eff_h) begin
            row_next = '0;
            mod_next = 2'd0;
        end else begin
            row_next = r_pre[ROW_W-1:0];
            mod_next = m_pre;
        end
        col_next = cur_c + COL_W'(1);

        m_dec        = (mod_next == 2'd0) ? 2'd2 : mod_next - 2'd1;
        ctl.col_zero = (cur_c == '0);
        ctl.c3_tap   = (cur_c >= COL_W'(3)) ? 2'd2 :
                       (cur_c == COL_W'(2)) ? 2'd1 : 2'd0;
        ctl.use_cur  = (row_next == '0);
        if (row_next >= ROW_W'(3)) begin
            ctl.line_sel[0] = m_dec;
            ctl.line_sel[1] = (mod_next == 2'd2) ? 2'd0 : mod_next + 2'd1;
            ctl.line_sel[2] = mod_next;
        end else if (row_next == ROW_W'(2)) begin
            ctl.line_sel = {2'd0, 2'd0, 2'd1};
        end else begin
            ctl.line_sel = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            thr_reg    <= THR_RST;
            col_reg    <= '0;
            row_reg    <= '0;
            mod_reg    <= 2'd0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:    width_reg  <= cfg_wdata[WIDTH_CFG_W-1:0];
                    REG_IMAGE_HEIGHT:   height_reg <= cfg_wdata[HEIGHT_CFG_W-1:0];
                    REG_EDGE_THRESHOLD: thr_reg    <= cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (push) begin
                col_reg <= col_next;
                row_reg <= row_next;
                mod_reg <= mod_next;
            end
        end
    end

    sxe_line_store #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_store (
        .aclk     (aclk),
        .push     (push),
        .wr_line  (mod_next),
        .addr     (cur_c[ADDR_W-1:0]),
        .wr_pixel (pixel_t'(s_tdata)),
        .line_tap (line_tap),
        .cur_tap  (cur_tap)
    );

    sxe_gradient u_gradient (
        .line_tap  (line_tap),
        .cur_tap   (cur_tap),
        .ctl       (ctl),
        .threshold (thr_reg),
        .result    (grad_result)
    );

    sxe_out_skid u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (grad_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = out_result;

    a_binary_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:0] == EDGE_ON || m_tdata[7:0] == EDGE_OFF) &&
                      (m_tdata[15:8] == EDGE_ON || m_tdata[15:8] == EDGE_OFF) &&
                      (m_tdata[23:16] == EDGE_ON || m_tdata[23:16] == EDGE_OFF)))
        else $error("edge output is neither full nor zero");

    a_col_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (col_reg != '0))
        else $error("column count zero after a transaction");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= COL_W'(MAX_WIDTH))
        else $error("column count beyond line length");

endmodule
